// File: rtl/core/mppc_pkg.sv
// Shared types, register indexes and the square-root scale table for the pixel converter.
`default_nettype none
package mppc_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_RED_MASK   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_MASK  = 2'd2;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned SHIFT_W = 5;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned SCALE_W = 17;
  localparam int unsigned NUM_CH  = 4;

  // Channel slots inside the per-channel arrays
  localparam int unsigned CH_A = 0;
  localparam int unsigned CH_R = 1;
  localparam int unsigned CH_G = 2;
  localparam int unsigned CH_B = 3;

  // Q1.16 scale for a = 255 and the rounding offset
  localparam logic [SCALE_W-1:0] SCALE_ONE = 17'd65536;
  localparam logic [15:0]        ROUND_HALF = 16'h8000;

  typedef logic [NUM_CH-1:0][WORD_W-1:0] mask_set_t;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] alpha;
  } pixel_t;

  typedef logic [SCALE_W-1:0] scale_lut_t [256];

  // Position of the lowest set bit; an empty mask gives zero
  function automatic logic [SHIFT_W-1:0] low_bit_pos(input logic [WORD_W-1:0] m);
    logic [SHIFT_W-1:0] p;
    p = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (m[i]) p = SHIFT_W'(i);
    end
    return p;
  endfunction

  // round(65536*sqrt(a/255)): largest n with (2n-1)^2*255 <= a*2^34
  function automatic logic [SCALE_W-1:0] sqrt_scale(input logic [7:0] a);
    logic [63:0] target;
    logic [63:0] odd;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] mid;
    target = {24'd0, a, 32'd0} << 2;
    lo = 32'd0;
    hi = 32'd65536;
    for (int k = 0; k < 18; k++) begin
      if (lo < hi) begin
        mid = (lo + hi + 32'd1) >> 1;
        odd = {31'd0, mid, 1'b0} - 64'd1;
        if (odd * odd * 64'd255 <= target) lo = mid;
        else hi = mid - 32'd1;
      end
    end
    return lo[SCALE_W-1:0];
  endfunction

  function automatic scale_lut_t build_scale_lut();
    scale_lut_t t;
    for (int i = 0; i < 256; i++) t[i] = sqrt_scale(8'(i));
    return t;
  endfunction

  // Elaboration-time table, read as plain logic
  localparam scale_lut_t SCALE_LUT = build_scale_lut();

endpackage
`default_nettype wire

// File: rtl/core/mppc_extract.sv
// Channel extraction: mask and shift-amount stage, then shift and clamp stage.
`default_nettype none
module mppc_extract (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire mppc_pkg::mask_set_t     masks,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire [mppc_pkg::WORD_W-1:0]   in_word,
  output logic                         out_valid,
  input  wire                          out_ready,
  output mppc_pkg::pixel_t             out_pix
);
  import mppc_pkg::*;

  logic                                  s1_valid_r, s1_valid_nxt;
  logic [NUM_CH-1:0][WORD_W-1:0]         s1_masked_r, s1_masked_nxt;
  logic [NUM_CH-1:0][SHIFT_W-1:0]        s1_shift_r, s1_shift_nxt;
  logic                                  s2_valid_r, s2_valid_nxt;
  pixel_t                                s2_pix_r, s2_pix_nxt;
  logic                                  s2_ready;
  logic [NUM_CH-1:0][CHAN_W-1:0]         clamped;

  assign s2_ready = !s2_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s2_ready;

  // Stage 1: apply masks, find shift amounts
  always_comb begin
    s1_valid_nxt = in_valid;
    for (int c = 0; c < NUM_CH; c++) begin
      s1_masked_nxt[c] = in_word & masks[c];
      s1_shift_nxt[c]  = low_bit_pos(masks[c]);
    end
  end

  // Stage 2: shift down and saturate to a byte
  always_comb begin
    logic [WORD_W-1:0] v;
    for (int c = 0; c < NUM_CH; c++) begin
      v = s1_masked_r[c] >> s1_shift_r[c];
      clamped[c] = (|v[WORD_W-1:CHAN_W]) ? {CHAN_W{1'b1}} : v[CHAN_W-1:0];
    end
    s2_valid_nxt      = s1_valid_r;
    s2_pix_nxt.alpha  = clamped[CH_A];
    s2_pix_nxt.red    = clamped[CH_R];
    s2_pix_nxt.green  = clamped[CH_G];
    s2_pix_nxt.blue   = clamped[CH_B];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (in_ready) s1_valid_r <= s1_valid_nxt;
      if (s2_ready) s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_masked_r <= s1_masked_nxt;
      s1_shift_r  <= s1_shift_nxt;
    end
    if (s2_ready) s2_pix_r <= s2_pix_nxt;
  end

  assign out_valid = s2_valid_r;
  assign out_pix   = s2_pix_r;

endmodule
`default_nettype wire

// File: rtl/core/mppc_scale.sv
// Premultiply: scale table lookup stage, then multiply and round stage.
`default_nettype none
module mppc_scale (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire mppc_pkg::pixel_t in_pix,
  output logic                out_valid,
  input  wire                 out_ready,
  output mppc_pkg::pixel_t    out_pix
);
  import mppc_pkg::*;

  localparam int unsigned PROD_W = CHAN_W + SCALE_W + 1;

  logic                 s3_valid_r, s3_valid_nxt;
  pixel_t               s3_pix_r, s3_pix_nxt;
  logic [SCALE_W-1:0]   s3_scale_r, s3_scale_nxt;
  logic                 s4_valid_r, s4_valid_nxt;
  pixel_t               s4_pix_r, s4_pix_nxt;
  logic                 s4_ready;

  assign s4_ready = !s4_valid_r || out_ready;
  assign in_ready = !s3_valid_r || s4_ready;

  // Stage 3: look up sqrt(a/255) in Q1.16
  always_comb begin
    s3_valid_nxt = in_valid;
    s3_pix_nxt   = in_pix;
    s3_scale_nxt = SCALE_LUT[in_pix.alpha];
  end

  // Rounded product, saturated to a byte
  function automatic logic [CHAN_W-1:0] premul(input logic [CHAN_W-1:0] c,
                                               input logic [SCALE_W-1:0] s);
    logic [PROD_W-1:0] p;
    logic [PROD_W-17:0] q;
    p = PROD_W'(c) * PROD_W'(s) + PROD_W'(ROUND_HALF);
    q = p[PROD_W-1:16];
    return (|q[PROD_W-17:CHAN_W]) ? {CHAN_W{1'b1}} : q[CHAN_W-1:0];
  endfunction

  // Stage 4: three 8x17 multiplies
  always_comb begin
    s4_valid_nxt     = s3_valid_r;
    s4_pix_nxt.alpha = s3_pix_r.alpha;
    s4_pix_nxt.red   = premul(s3_pix_r.red, s3_scale_r);
    s4_pix_nxt.green = premul(s3_pix_r.green, s3_scale_r);
    s4_pix_nxt.blue  = premul(s3_pix_r.blue, s3_scale_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      if (in_ready) s3_valid_r <= s3_valid_nxt;
      if (s4_ready) s4_valid_r <= s4_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s3_pix_r   <= s3_pix_nxt;
      s3_scale_r <= s3_scale_nxt;
    end
    if (s4_ready) s4_pix_r <= s4_pix_nxt;
  end

  assign out_valid = s4_valid_r;
  assign out_pix   = s4_pix_r;

  // Zero alpha must give a zero scale
  a_scale_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r && s3_pix_r.alpha == '0 |-> s3_scale_r == '0)
    else $error("scale not zero for zero alpha");

  // Full alpha must give unity scale
  a_scale_one: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r && s3_pix_r.alpha == {CHAN_W{1'b1}} |-> s3_scale_r == SCALE_ONE)
    else $error("scale not unity for full alpha");

  // Transparent result carries no color
  a_clear_black: assert property (@(posedge clk) disable iff (!rst_n)
    s4_valid_r && s4_pix_r.alpha == '0 |->
      s4_pix_r.red == '0 && s4_pix_r.green == '0 && s4_pix_r.blue == '0)
    else $error("color left in transparent pixel");

  // An accepted transaction occupies stage 3 next cycle
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s3_valid_r)
    else $error("accepted transaction lost at stage 3");

endmodule
`default_nettype wire

// File: rtl/core/masked_pixel_premultiply_converter.sv
// Top level: mask registers and the four-stage pixel unpack and premultiply pipeline.
//
// Usage:
//   in_tdata carries one 32-bit source pixel word per transaction. Red, green
//   and blue are cut out with the three mask registers, alpha with the bits no
//   mask covers; each is shifted down by its mask's lowest set bit and clamped
//   to 255. Colors are scaled by sqrt(alpha/255) with rounding.
//   out_tdata carries alpha, red, green, blue bytes, one transaction per input.
//   Masks are written through cfg_wen/cfg_index/cfg_wdata while the pipeline
//   is empty; index 3 is ignored.
// Path: from input acceptance to out_tvalid through the mask, shift/clamp,
//   table lookup and multiply/round registers, in that order.
// Throughput: one pixel per cycle; each stage holds one pixel and hands it on
//   whenever the next stage is empty or moving.
// Reset: clears all stage valid bits and loads masks 0x00FF0000, 0x0000FF00,
//   0x000000FF.
// Stall: when out_tready is low the last stage holds its result; earlier stages
//   keep filling empty slots, and in_tready drops once all four are full.
`default_nettype none
module masked_pixel_premultiply_converter (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_tvalid,
  output logic                  in_tready,
  input  wire [31:0]            in_tdata,   // [31:0] source_pixel
  output logic                  out_tvalid,
  input  wire                   out_tready,
  output logic [31:0]           out_tdata,  // [7:0] alpha_out, [15:8] red_out,
                                            // [23:16] green_out, [31:24] blue_out
  input  wire                   cfg_wen,
  input  wire [mppc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [mppc_pkg::WORD_W-1:0]    cfg_wdata
);
  import mppc_pkg::*;

  logic [WORD_W-1:0] red_mask_r, green_mask_r, blue_mask_r;
  mask_set_t         masks;
  logic              mid_valid, mid_ready;
  pixel_t            mid_pix, res_pix;

  // Mask registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_mask_r   <= 32'h00FF_0000;
      green_mask_r <= 32'h0000_FF00;
      blue_mask_r  <= 32'h0000_00FF;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_RED_MASK:   red_mask_r   <= cfg_wdata;
        REG_GREEN_MASK: green_mask_r <= cfg_wdata;
        REG_BLUE_MASK:  blue_mask_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Alpha takes every bit the color masks leave free
  always_comb begin
    masks       = '0;
    masks[CH_A] = ~(red_mask_r | green_mask_r | blue_mask_r);
    masks[CH_R] = red_mask_r;
    masks[CH_G] = green_mask_r;
    masks[CH_B] = blue_mask_r;
  end

  mppc_extract u_extract (
    .clk       (clk),
    .rst_n     (rst_n),
    .masks     (masks),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_word   (in_tdata),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_pix   (mid_pix)
  );

  mppc_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_pix    (mid_pix),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pix   (res_pix)
  );

  assign out_tdata = res_pix;

endmodule
`default_nettype wire

// File: dv/mppc_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the pixel converter: mirrors the mask registers, predicts and compares results.
module mppc_checker (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  input  wire                          in_tready,
  input  wire [31:0]                   in_tdata,   // [31:0] source_pixel
  input  wire                          out_tvalid,
  input  wire                          out_tready,
  input  wire [31:0]                   out_tdata,  // [7:0] alpha, [15:8] red,
                                                   // [23:16] green, [31:24] blue
  input  wire                          cfg_wen,
  input  wire [mppc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [31:0]                   cfg_wdata,
  output int                           err_count,
  output int                           pending
);
  import mppc_pkg::*;

  logic [WORD_W-1:0]  red_mask_q;
  logic [WORD_W-1:0]  green_mask_q;
  logic [WORD_W-1:0]  blue_mask_q;
  logic [SCALE_W-1:0] root_scale [256];
  pixel_t             expected_pixels [$];

  // Q1.16 root of a/255, built bit by bit from the top: largest n with
  // (2n-1)^2 * 255 <= a * 2^34, capped at 65536
  function automatic logic [SCALE_W-1:0] root_q16(input int unsigned a);
    longint unsigned    bound;
    longint unsigned    odd;
    logic [SCALE_W-1:0] n;
    logic [SCALE_W-1:0] cand;
    bound = longint'(a) << 34;
    n = '0;
    for (int b = SCALE_W - 1; b >= 0; b--) begin
      cand = n | (SCALE_W'(1) << b);
      odd  = 64'(cand) * 64'd2 - 64'd1;
      if (cand <= SCALE_W'(65536) && odd * odd * 64'd255 <= bound) n = cand;
    end
    return n;
  endfunction

  // Index of the lowest set bit, zero for an empty mask
  function automatic int unsigned lsb_index(input logic [WORD_W-1:0] m);
    int unsigned p;
    bit          found;
    p = 0;
    found = 1'b0;
    for (int i = 0; i < WORD_W; i++) begin
      if (!found && m[i]) begin
        p = i;
        found = 1'b1;
      end
    end
    return p;
  endfunction

  // Masked field shifted down by its lowest bit, saturated to a byte
  function automatic logic [CHAN_W-1:0] field_value(input logic [WORD_W-1:0] word,
                                                   input logic [WORD_W-1:0] m);
    logic [WORD_W-1:0] v;
    v = (word & m) >> lsb_index(m);
    return (v > 32'd255) ? 8'hFF : v[CHAN_W-1:0];
  endfunction

  // Color times scale with round-half-up, saturated to a byte
  function automatic logic [CHAN_W-1:0] scale_color(input logic [CHAN_W-1:0] c,
                                                   input logic [SCALE_W-1:0] s);
    logic [31:0] prod;
    prod = (32'(c) * 32'(s) + 32'd32768) >> 16;
    return (prod > 32'd255) ? 8'hFF : prod[CHAN_W-1:0];
  endfunction

  function automatic pixel_t premultiplied_pixel(input logic [WORD_W-1:0] px);
    pixel_t             res;
    logic [WORD_W-1:0]  alpha_mask;
    logic [SCALE_W-1:0] s;
    alpha_mask = ~(red_mask_q | green_mask_q | blue_mask_q);
    res.alpha = field_value(px, alpha_mask);
    s = root_scale[res.alpha];
    res.red   = scale_color(field_value(px, red_mask_q), s);
    res.green = scale_color(field_value(px, green_mask_q), s);
    res.blue  = scale_color(field_value(px, blue_mask_q), s);
    return res;
  endfunction

  task automatic report_error(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    err_count++;
  endtask

  initial begin
    err_count = 0;
    pending = 0;
    for (int a = 0; a < 256; a++) root_scale[a] = root_q16(a);
  end

  // Watch mask writes, input and output transactions on each rising edge
  always @(posedge clk) begin : watch
    pixel_t got;
    pixel_t want;
    if (!rst_n) begin
      red_mask_q   = 32'h00FF0000;
      green_mask_q = 32'h0000FF00;
      blue_mask_q  = 32'h000000FF;
      expected_pixels.delete();
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          REG_RED_MASK:   red_mask_q   = cfg_wdata;
          REG_GREEN_MASK: green_mask_q = cfg_wdata;
          REG_BLUE_MASK:  blue_mask_q  = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_pixels.size() == 0) begin
          report_error($sformatf("result 0x%08h with nothing expected", out_tdata));
        end else begin
          want = expected_pixels.pop_front();
          if (got.alpha !== want.alpha)
            report_error($sformatf("alpha expected 0x%02h got 0x%02h", want.alpha, got.alpha));
          if (got.red !== want.red)
            report_error($sformatf("red expected 0x%02h got 0x%02h", want.red, got.red));
          if (got.green !== want.green)
            report_error($sformatf("green expected 0x%02h got 0x%02h", want.green, got.green));
          if (got.blue !== want.blue)
            report_error($sformatf("blue expected 0x%02h got 0x%02h", want.blue, got.blue));
        end
      end
      if (in_tvalid && in_tready) expected_pixels.push_back(premultiplied_pixel(in_tdata));
    end
    pending = expected_pixels.size();
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// Testbench top: drives pixels and mask writes into the converter and gives the verdict.
module tb;
  import mppc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int STALL_LIMIT     = 5000;
  localparam int HOLD_CYCLES     = 60;
  localparam int RAND_PHASES     = 6;
  localparam int ITEMS_PER_PHASE = 300;
  localparam int DRAIN_CYCLES    = 16;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [31:0]          in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [31:0]          out_tdata;
  logic                 cfg_wen;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_wdata;

  int          err_count;
  int          pending;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_request = 1'b0;
  int          stall_cycles = 0;
  logic [31:0] cur_red   = 32'h00FF0000;
  logic [31:0] cur_green = 32'h0000FF00;
  logic [31:0] cur_blue  = 32'h000000FF;

  masked_pixel_premultiply_converter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  mppc_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .err_count  (err_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random back-pressure, plus a long hold-off on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Cycles without any transaction on either channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // One pixel transaction, with random idle cycles ahead of it
  task automatic send_pixel(input logic [31:0] px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Mask update on an empty pipeline; the unused index gets a junk write too
  task automatic load_masks(input logic [31:0] r, input logic [31:0] g, input logic [31:0] b);
    wait_drained();
    cfg_wen   <= 1'b1;
    cfg_index <= REG_RED_MASK;
    cfg_wdata <= r;
    @(negedge clk);
    cfg_index <= REG_GREEN_MASK;
    cfg_wdata <= g;
    @(negedge clk);
    cfg_index <= REG_BLUE_MASK;
    cfg_wdata <= b;
    @(negedge clk);
    cfg_index <= REG_UNUSED;
    cfg_wdata <= $urandom;
    @(negedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
    cur_red   = r;
    cur_green = g;
    cur_blue  = b;
  endtask

  function automatic logic [31:0] random_mask();
    int unsigned w;
    int unsigned lsb;
    case ($urandom_range(5))
      0: begin
        w   = $urandom_range(1, 32);
        lsb = $urandom_range(0, 32 - w);
        return 32'(((64'd1 << w) - 64'd1) << lsb);
      end
      1: return $urandom;
      2: return 32'h0;
      3: return 32'hFFFFFFFF;
      4: return 32'd1 << $urandom_range(31);
      default: return 32'hFF << $urandom_range(24);
    endcase
  endfunction

  // Mostly random words; some with the alpha field empty or full
  function automatic logic [31:0] random_pixel();
    logic [31:0] alpha_mask;
    alpha_mask = ~(cur_red | cur_green | cur_blue);
    case ($urandom_range(9))
      0: return $urandom & ~alpha_mask;
      1: return $urandom | alpha_mask;
      2: return 32'($urandom_range(255));
      3: return 32'hFFFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_wen   = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 26;
    recv_idle_pct = 85;

    // Reset masks: field extremes, alpha zero, one and full
    send_pixel(32'h00000000);
    send_pixel(32'hFFFFFFFF);
    send_pixel(32'h00FFFFFF);
    send_pixel(32'hFF000000);
    send_pixel(32'h01FFFFFF);
    send_pixel(32'hFEFFFFFF);
    send_pixel(32'hFF808080);
    send_pixel(32'h80FF00FF);
    send_pixel(32'h7F123456);
    send_pixel(32'h55AA55AA);
    send_pixel(32'hAA55AA55);

    // Wide masks that clamp, an empty green mask, no bits left for alpha
    load_masks(32'hFFFF0000, 32'h00000000, 32'h0000FFFF);
    send_pixel(32'hFFFFFFFF);
    send_pixel(32'h00FF00FF);
    send_pixel(32'h12345678);

    // Overlapping masks; alpha gets a split mask
    load_masks(32'h00000FF0, 32'h00000FF0, 32'h000000F0);
    send_pixel(32'hFFFFFFFF);
    send_pixel(32'h00000A5F);
    send_pixel(32'hF000000F);

    // Sparse red, single-bit green, full blue
    load_masks(32'h80000001, 32'h00000100, 32'hFFFFFFFF);
    send_pixel(32'h00000000);
    send_pixel(32'h80000000);
    send_pixel(32'h00000001);
    send_pixel(32'hFFFFFFFF);

    load_masks(32'h00000000, 32'hFFFFFFFF, 32'h00000000);
    send_pixel(32'h12345678);
    load_masks(32'hFFFFFFFF, 32'h00000000, 32'h00000000);
    send_pixel(32'h9ABCDEF0);

    // Random phases: pairs of phases per idling pattern
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: load_masks(32'h000000FF, 32'h0000FF00, 32'h00FF0000);
        1: load_masks(32'h0000F800, 32'h000007E0, 32'h0000001F);
        default: load_masks(random_mask(), random_mask(), random_mask());
      endcase
      case (ph / 2)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct = 85;
        end
        1: begin
          send_idle_pct = 85;
          recv_idle_pct = 26;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i == ITEMS_PER_PHASE / 2) begin
          if (ph == 1 || ph == 4) hold_request = 1'b1;
          if (ph == 3) wait_drained();
        end
        send_pixel(random_pixel());
      end
    end

    // Drain and settle
    in_tvalid <= 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (err_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
